[hdl/yenc_pkg.sv]
// shared types and constants for the yenc line encoder
`default_nettype none
package yenc_pkg;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned POS_W = 11;

  localparam logic [7:0] SHIFT_OFS = 8'h2A;
  localparam logic [7:0] ESC_OFS   = 8'h40;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h3D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPC = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam logic [LEN_W-1:0] LINE_LEN_RST = 10'd128;

  localparam logic [1:0] STEP_ESC  = 2'd0;
  localparam logic [1:0] STEP_DATA = 2'd1;
  localparam logic [1:0] STEP_CR   = 2'd2;
  localparam logic [1:0] STEP_LF   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_end;
  } yenc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } yenc_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       esc;
    logic       crlf;
  } yenc_burst_t;

endpackage
`default_nettype wire

[hdl/yenc_line_encoder.sv]
// top level of the yenc line encoder
// Encodes one raw byte per request into yEnc text: each byte is shifted by 42, critical
// characters are sent as '=' plus the byte shifted by a further 64, and CR LF closes a
// line when the configured line length is reached or the request marks the end of a
// block. The result port carries one character per cycle unless out_ready stalls it; a
// request yields one character plain, two escaped, and two more when it ends a line (one
// to four characters); a new request is taken in the cycle its last character moves to the
// output register. The user must see that line_length is written through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this. It resets to 128.
`default_nettype none
module yenc_line_encoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire yenc_pkg::yenc_in_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output yenc_pkg::yenc_out_t            out_data,
  input  wire logic                      cfg_we,
  input  wire logic [yenc_pkg::LEN_W-1:0] cfg_wdata
);
  import yenc_pkg::*;

  yenc_burst_t burst;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  yenc_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .burst     (burst)
  );

  yenc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .burst     (burst),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[hdl/yenc_enc.sv]
// per-request encode decision and line position tracking
`default_nettype none
module yenc_enc (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [yenc_pkg::LEN_W-1:0] cfg_wdata,
  input  wire logic                      in_fire,
  input  wire yenc_pkg::yenc_in_t        in_data,
  output yenc_pkg::yenc_burst_t          burst
);
  import yenc_pkg::*;

  logic [LEN_W-1:0] line_len_r;
  logic [POS_W-1:0] line_pos_r;
  logic [POS_W-1:0] line_pos_nxt;
  logic [7:0]       shifted;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   pos_after;
  logic [POS_W:0]   len_ext;
  logic             esc_always;
  logic             esc_start;
  logic             esc_end;
  logic             esc;
  logic             crlf;

  always_comb begin
    shifted    = in_data.in_byte + SHIFT_OFS;
    len_ext    = {2'b00, line_len_r};
    pos_inc    = {1'b0, line_pos_r} + 12'd1;
    esc_always = (shifted == CH_NUL) || (shifted == CH_LF) ||
                 (shifted == CH_CR) || (shifted == CH_ESC);
    esc_start  = (line_pos_r == '0) &&
                 ((shifted == CH_TAB) || (shifted == CH_SPC) || (shifted == CH_DOT));
    esc_end    = (pos_inc >= len_ext) && ((shifted == CH_TAB) || (shifted == CH_SPC));
    esc        = esc_always || esc_start || esc_end;
    pos_after  = pos_inc + {{POS_W{1'b0}}, esc};
    crlf       = (pos_after >= len_ext) || in_data.block_end;
    line_pos_nxt = crlf ? '0 : pos_after[POS_W-1:0];
    burst.ch   = esc ? (shifted + ESC_OFS) : shifted;
    burst.esc  = esc;
    burst.crlf = crlf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= LINE_LEN_RST;
      line_pos_r <= '0;
    end else begin
      if (cfg_we) begin
        line_len_r <= cfg_wdata;
      end
      if (in_fire) begin
        line_pos_r <= line_pos_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/yenc_emit.sv]
// holds one encoded request and streams its characters through an output register
`default_nettype none
module yenc_emit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire yenc_pkg::yenc_burst_t burst,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output yenc_pkg::yenc_out_t       out_data
);
  import yenc_pkg::*;

  yenc_burst_t bst_r;
  logic        bst_vld_r;
  logic [1:0]  step_r;
  logic        ovld_r;
  yenc_out_t   odata_r;
  logic [7:0]  cur_ch;
  logic        cur_last;
  logic        out_take;
  logic        pop;

  always_comb begin
    case (step_r)
      STEP_ESC:  cur_ch = CH_ESC;
      STEP_DATA: cur_ch = bst_r.ch;
      STEP_CR:   cur_ch = CH_CR;
      STEP_LF:   cur_ch = CH_LF;
      default:   cur_ch = bst_r.ch;
    endcase
    cur_last = bst_r.crlf ? (step_r == STEP_LF) : (step_r == STEP_DATA);
    out_take = !ovld_r || out_ready;
    pop      = bst_vld_r && out_take;
    in_ready = !bst_vld_r || (cur_last && out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_vld_r <= 1'b0;
      step_r    <= STEP_DATA;
      ovld_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        bst_vld_r <= 1'b1;
        step_r    <= burst.esc ? STEP_ESC : STEP_DATA;
      end else if (pop && cur_last) begin
        bst_vld_r <= 1'b0;
      end else if (pop) begin
        step_r <= step_r + 2'd1;
      end
      if (out_take) begin
        ovld_r <= bst_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bst_r <= burst;
    end
    if (out_take) begin
      odata_r.out_byte <= cur_ch;
      odata_r.run_last <= cur_last;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

endmodule
`default_nettype wire

[hdl/yenc_checker.sv]
// port-level checks for the yenc line encoder
`default_nettype none
module yenc_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire yenc_pkg::yenc_out_t       out_data
);
  import yenc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.out_byte == CH_CR)
    |=> out_valid && (out_data.out_byte == CH_LF) && out_data.run_last)
    else $error("CR not followed by final LF");

  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_byte == CH_ESC || out_data.out_byte == CH_CR)
    |-> !out_data.run_last)
    else $error("escape or CR marked as final character");

endmodule

bind yenc_line_encoder yenc_checker u_yenc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[verif/tb_yenc_line_encoder.sv]
// testbench for the yenc line encoder: scoreboard predictor and handshake drivers
`timescale 1ns / 1ps
module tb_yenc_line_encoder;
  import yenc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  class yenc_scoreboard;
    logic [LEN_W-1:0] line_len;
    logic [POS_W-1:0] line_pos;
    yenc_out_t        expected_chars[$];
    int               errors;

    function new();
      line_len = LINE_LEN_RST;
      line_pos = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_request(yenc_in_t req);
      logic [7:0] c;
      int         pos;
      logic       esc;
      yenc_out_t  burst[$];
      c   = req.in_byte + SHIFT_OFS;
      pos = int'(line_pos);
      esc = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_ESC) ||
            (pos == 0 && (c == CH_TAB || c == CH_SPC || c == CH_DOT)) ||
            (pos + 1 >= int'(line_len) && (c == CH_TAB || c == CH_SPC));
      if (esc) begin
        burst.push_back({CH_ESC, 1'b0});
        c = c + ESC_OFS;
        pos++;
      end
      burst.push_back({c, 1'b0});
      pos++;
      if (pos >= int'(line_len) || req.block_end) begin
        burst.push_back({CH_CR, 1'b0});
        burst.push_back({CH_LF, 1'b0});
        pos = 0;
      end
      burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) expected_chars.push_back(burst[i]);
      line_pos = pos[POS_W-1:0];
    endfunction

    function void check_char(yenc_out_t got);
      yenc_out_t exp_char;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char, expected none got %02h/%0b",
                 $time, got.out_byte, got.run_last);
        errors++;
        return;
      end
      exp_char = expected_chars.pop_front();
      if (got.out_byte !== exp_char.out_byte) begin
        $display("%0t: out_byte mismatch, expected %02h got %02h",
                 $time, exp_char.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== exp_char.run_last) begin
        $display("%0t: run_last mismatch, expected %0b got %0b",
                 $time, exp_char.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  yenc_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  yenc_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  yenc_scoreboard sb = new();
  int unsigned    cycles = 0;
  int             rx_hold = 0;
  int             rx_wait;
  bit             rx_calm = 1'b0;
  bit             tx_calm = 1'b0;

  // tab/space/dot at line edges, every always-escaped char, field extremes
  yenc_in_t probe_set [18] = '{
    {8'hDF, 1'b0}, {8'h04, 1'b0}, {8'hF6, 1'b0}, {8'h04, 1'b0}, {8'hDF, 1'b0},
    {8'hDF, 1'b0}, {8'hD6, 1'b0}, {8'hE0, 1'b0}, {8'hE3, 1'b0}, {8'h13, 1'b0},
    {8'h00, 1'b1}, {8'hFF, 1'b1}, {8'hF6, 1'b0}, {8'h04, 1'b1}, {8'hAA, 1'b0},
    {8'h55, 1'b0}, {8'hD5, 1'b0}, {8'hD6, 1'b1}
  };

  logic [LEN_W-1:0] phase_len [8] = '{
    10'd1, 10'd2, 10'd5, 10'd1023, 10'd0, 10'd37, 10'd128, 10'd9
  };

  logic [7:0] critical_raw [7] = '{8'hD6, 8'hE0, 8'hE3, 8'h13, 8'hDF, 8'hF6, 8'h04};

  yenc_line_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_char(out_data);
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_hold <= rx_wait;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_request(input yenc_in_t req);
    int gap;
    if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic set_line_length(input logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.line_len = len;
  endtask

  function automatic yenc_in_t random_request();
    yenc_in_t req;
    if ($urandom_range(0, 9) < 4) req.in_byte = critical_raw[$urandom_range(0, 6)];
    else req.in_byte = 8'($urandom_range(0, 255));
    req.block_end = ($urandom_range(0, 7) == 0);
    return req;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_line_length(10'd4);
    foreach (probe_set[i]) push_request(probe_set[i]);

    foreach (phase_len[k]) begin
      set_line_length(phase_len[k]);
      repeat (13) push_request(random_request());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
